/* rtl/core/wve_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wve_pkg
// shared types, widths and constants of the windowed velocity estimator
// ----------------------------------------------------------------------------
package wve_pkg;

   // field and register widths
   localparam int DATA_W      = 32;
   localparam int WL_W        = 5;
   localparam int SHIFT_W     = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   // sample window
   localparam int WINDOW_DEPTH = 32;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);

   // divider: one quotient bit per step
   localparam int DIV_STEPS = DATA_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // register reset values
   localparam logic [WL_W-1:0]    WL_RESET    = WL_W'(29);
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = '0;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_VELOCITY_SHIFT = CSR_INDEX_W'(1);

   // window length reduced modulo the depth, one entry per register value
   typedef logic [IDX_W-1:0] back_table_type [2**WL_W];

   function automatic back_table_type build_back_table();
      back_table_type t;
      for (int i = 0; i < 2**WL_W; i++) begin
         t[i] = IDX_W'(i % WINDOW_DEPTH);
      end
      return t;
   endfunction

   localparam back_table_type BACK_TABLE = build_back_table();

   // controller to datapath commands
   typedef struct packed {
      logic accept;     // take the request, write the window, read the tail
      logic fetch;      // form the shifted difference
      logic absolute;   // take the magnitude for the divider
      logic div_step;   // one restoring division step
      logic load_out;   // move the quotient into the response register
   } wve_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;   // response register can take a new result this cycle
   } wve_sts_type;

endpackage
`default_nettype wire

/* rtl/core/wve_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wve_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wve_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/wve_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wve_ctrl
// sequencer: accept, fetch, magnitude, divide, hand over
// ----------------------------------------------------------------------------
module wve_ctrl
   import wve_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   output wve_cmd_type cmd,
   input  wve_sts_type sts
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FETCH  = 5'b00010,
      ST_ABS    = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             last_step;

   assign last_step = (count_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_ABS;
         end
         ST_ABS: begin
            cmd.absolute = 1'b1;
            count_in     = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   a_accept_then_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.fetch)
      else $error("fetch did not follow an accepted request");

   a_divide_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && last_step) |=> (state_ff == ST_DONE))
      else $error("divider did not finish after its last step");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded while the response register was busy");

endmodule
`default_nettype wire

/* rtl/core/wve_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wve_dpath
// window store, difference and shift, restoring divider, response register
// ----------------------------------------------------------------------------
module wve_dpath
   import wve_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [DATA_W-1:0]       req_tdata,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [DATA_W-1:0]       rsp_tdata,
   input  wire                     csr_we,
   input  wire  [CSR_INDEX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_wdata,
   input  wve_cmd_type             cmd,
   output wve_sts_type             sts
);

   localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(WINDOW_DEPTH);

   // configuration
   logic [WL_W-1:0]    wl_ff;
   logic [SHIFT_W-1:0] shift_ff;

   // window control
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [WINDOW_DEPTH-1:0] valid_ff;
   logic [IDX_W-1:0]        back;
   logic [IDX_W:0]          tail_diff;
   logic [IDX_W-1:0]        tail;
   logic [DATA_W-1:0]       rd_data;

   // per request
   logic [DATA_W-1:0] sample_ff;
   logic              tail_valid_ff;
   logic              same_slot_ff;
   logic [DATA_W-1:0] old_sample;
   logic [DATA_W-1:0] diff;
   logic [DATA_W-1:0] shifted;

   // divider
   logic [DATA_W-1:0] dvd_ff;
   logic [WL_W-1:0]   rem_ff;
   logic [WL_W-1:0]   div_ff;
   logic              neg_ff;
   logic [WL_W:0]     rem_shift;
   logic [WL_W:0]     rem_sub;
   logic              ge;

   // response
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff    <= WL_RESET;
         shift_ff <= SHIFT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH:  wl_ff    <= csr_wdata[WL_W-1:0];
            CSR_VELOCITY_SHIFT: shift_ff <= csr_wdata[SHIFT_W-1:0];
         endcase
      end
   end

   // tail slot behind the head, wrapped into the window
   assign back      = BACK_TABLE[wl_ff];
   assign tail_diff = {1'b0, head_ff} - {1'b0, back};
   assign tail      = tail_diff[IDX_W] ? IDX_W'(tail_diff + DEPTH_EXT)
                                       : tail_diff[IDX_W-1:0];
   assign head_in   = (head_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                            : head_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         valid_ff <= '0;
      end else if (cmd.accept) begin
         head_ff           <= head_in;
         valid_ff[head_ff] <= 1'b1;
      end
   end

   wve_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (head_ff),
      .wr_data (req_tdata),
      .rd_en   (cmd.accept),
      .rd_addr (tail),
      .rd_data (rd_data)
   );

   // difference and shift
   assign old_sample = tail_valid_ff ? rd_data : '0;
   assign diff       = same_slot_ff ? '0 : (sample_ff - old_sample);
   assign shifted    = diff << shift_ff;

   // restoring step: remainder stays below the divisor
   assign rem_shift = {rem_ff, dvd_ff[DATA_W-1]};
   assign rem_sub   = rem_shift - {1'b0, div_ff};
   assign ge        = (rem_shift >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff     <= req_tdata;
         tail_valid_ff <= valid_ff[tail];
         same_slot_ff  <= (back == '0);
      end
      if (cmd.fetch) begin
         dvd_ff <= shifted;
         neg_ff <= shifted[DATA_W-1];
         rem_ff <= '0;
         div_ff <= (wl_ff == '0) ? WL_W'(1) : wl_ff;
      end
      if (cmd.absolute) begin
         dvd_ff <= neg_ff ? (~dvd_ff + DATA_W'(1)) : dvd_ff;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? rem_sub[WL_W-1:0] : rem_shift[WL_W-1:0];
         dvd_ff <= {dvd_ff[DATA_W-2:0], ge};
      end
      if (cmd.load_out) begin
         rsp_data_ff <= neg_ff ? (~dvd_ff + DATA_W'(1)) : dvd_ff;
      end
   end

   // response register
   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> (rem_ff < div_ff))
      else $error("division remainder reached the divisor");

endmodule
`default_nettype wire

/* rtl/core/windowed_velocity_estimator_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_velocity_estimator_top
// finite difference velocity over a circular window of position samples
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req_     in         req_tvalid/req_tready  req_tdata[31:0] position_sample
//  rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata[31:0] velocity
//  csr_     in         csr_we (no wait)       csr_index, csr_wdata[4:0]
//
//  steps from acceptance to a loaded response: window read at the accepting
//  edge, then difference and shift, magnitude, 32 divider steps and the load;
//  a new request is accepted only after the previous result has been loaded
//  reset is synchronous and active high; unwritten window slots read as zero
//  a finished result waits in the response register while the next request
//  is accepted; a stall on rsp_ only holds the sequencer at hand-over
//
module windowed_velocity_estimator_top
   import wve_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   // request: position_sample [31:0]
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [DATA_W-1:0]       req_tdata,
   // response: velocity [31:0]
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [DATA_W-1:0]       rsp_tdata,
   // register writes: 0 window_length, 1 velocity_shift
   input  wire                     csr_we,
   input  wire  [CSR_INDEX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_wdata
);

   wve_cmd_type cmd;   // sequencer commands
   wve_sts_type sts;   // datapath status

   // sequencer: one request at a time, divider steps counted here
   wve_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath: window ram, difference, divider and response register
   wve_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
`default_nettype wire

/* tb/windowed_velocity_estimator_top_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_velocity_estimator_top_tb
// self-checking bench for the windowed finite difference velocity estimator
//
// position requests are streamed in and velocity responses streamed out under
// several register settings and idle patterns; a predictor keeps its own copy
// of the sample window and register values and queues the velocity expected
// for every accepted request, which is compared with each response in order
// ----------------------------------------------------------------------------
module windowed_velocity_estimator_top_tb
   import wve_pkg::*;
();

   // run length and idle patterns
   localparam int CYCLE_LIMIT    = 600000;
   localparam int PHASE_REQUESTS = 160;
   localparam int RANDOM_PHASES  = 8;
   localparam int BUSY_PCT       = 54;
   localparam int SHARED_PCT     = 27;
   localparam int DRAIN_CYCLES   = 40;

   // --------------------------------------------------------------------------
   // predictor and store of expected velocities
   // --------------------------------------------------------------------------
   class velocity_predictor;
      logic [DATA_W-1:0]  window [WINDOW_DEPTH];
      logic [IDX_W-1:0]   head;
      logic [WL_W-1:0]    window_length;
      logic [SHIFT_W-1:0] velocity_shift;
      logic [DATA_W-1:0]  expected_velocity [$];
      int                 failures;

      function new();
         for (int i = 0; i < WINDOW_DEPTH; i++) window[i] = '0;
         head           = '0;
         window_length  = WL_RESET;
         velocity_shift = SHIFT_RESET;
         failures       = 0;
      endfunction

      // only the low bits of the shift survive a write; the length keeps every bit
      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         if (index == CSR_WINDOW_LENGTH)
            window_length = value[WL_W-1:0];
         else if (index == CSR_VELOCITY_SHIFT)
            velocity_shift = value[SHIFT_W-1:0];
      endfunction

      function void note_sample(logic [DATA_W-1:0] sample);
         logic [IDX_W-1:0]  tail;
         logic [DATA_W-1:0] diff;
         int                dividend;
         int                divisor;
         // new sample goes in first, so a zero length differences it with itself
         window[head] = sample;
         tail         = head - IDX_W'(window_length);
         diff         = sample - window[tail];
         diff         = diff << velocity_shift;
         dividend     = diff;
         divisor      = (window_length == '0) ? 1 : int'(window_length);
         expected_velocity.push_back(DATA_W'(dividend / divisor));
         head = head + IDX_W'(1);
      endfunction

      function void check_velocity(logic [DATA_W-1:0] actual);
         logic [DATA_W-1:0] wanted;
         if (expected_velocity.size() == 0) begin
            $error("velocity response with nothing expected: actual %0d", $signed(actual));
            failures++;
            return;
         end
         wanted = expected_velocity.pop_front();
         if (actual !== wanted) begin
            $error("velocity mismatch: expected %0d, actual %0d",
                   $signed(wanted), $signed(actual));
            failures++;
         end
      endfunction

      function int pending();
         return expected_velocity.size();
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // block interface, all inputs known from time zero
   // --------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   wire                    req_tready;
   logic [DATA_W-1:0]      req_tdata  = '0;
   wire                    rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire  [DATA_W-1:0]      rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   velocity_predictor  predictor;
   logic [DATA_W-1:0]  position_queue [$];   // requests waiting to be sent
   logic [DATA_W-1:0]  last_position = '0;
   logic [DATA_W-1:0]  ramp_rate     = '0;
   int                 sender_idle_pct    = 0;
   int                 receiver_stall_pct = 0;
   int                 cycle_count        = 0;

   windowed_velocity_estimator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // position_sample [31:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // velocity [31:0]
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: check on the handshake, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         predictor.check_velocity(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------

   // both registers back to back, write enable held across the pair
   task automatic program_registers(input logic [CSR_DATA_W-1:0] length_value,
                                    input logic [CSR_DATA_W-1:0] shift_value);
      csr_we    <= 1'b1;
      csr_index <= CSR_WINDOW_LENGTH;
      csr_wdata <= length_value;
      @(posedge clock);
      predictor.write_register(CSR_WINDOW_LENGTH, length_value);
      csr_index <= CSR_VELOCITY_SHIFT;
      csr_wdata <= shift_value;
      @(posedge clock);
      predictor.write_register(CSR_VELOCITY_SHIFT, shift_value);
      csr_we    <= 1'b0;
   endtask

   // send every queued request, then wait until all responses are in
   task automatic play_requests(input int send_pct, input int recv_pct);
      logic [DATA_W-1:0] sample;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
      while (position_queue.size() != 0) begin
         sample = position_queue.pop_front();
         while ($urandom_range(99) < sender_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= sample;
         do @(posedge clock); while (!req_tready);
         predictor.note_sample(sample);
      end
      req_tvalid <= 1'b0;
      // every request yields a response, so an empty store means idle
      while (predictor.pending() != 0) @(posedge clock);
   endtask

   // mostly steady ramps like a real axis, with jumps, noise and extremes
   function automatic logic [DATA_W-1:0] next_position(input logic [DATA_W-1:0] prev);
      logic [DATA_W-1:0] value;
      int                kind;
      kind = $urandom_range(9);
      if ($urandom_range(19) == 0) begin
         ramp_rate = $urandom() >> $urandom_range(31, 4);
         if ($urandom_range(1) == 1) ramp_rate = -ramp_rate;
      end
      case (kind)
         7: value = $urandom();
         8: begin
            case ($urandom_range(3))
               0:       value = 32'h7fff_ffff;
               1:       value = 32'h8000_0000;
               2:       value = '0;
               default: value = '1;
            endcase
         end
         9:       value = prev + $urandom();
         default: value = prev + ramp_rate + DATA_W'($urandom_range(6)) - 32'd3;
      endcase
      return value;
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] length_value;
      logic [CSR_DATA_W-1:0] shift_value;
      predictor = new();

      // single reset at the start
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, window still empty, signed extremes
      position_queue = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001,
                         32'h0000_0000};
      play_requests(0, 0);

      // shortest window with the largest shift: difference and shift both wrap
      program_registers(CSR_DATA_W'(1), CSR_DATA_W'(15));
      position_queue = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff,
                         32'h0001_0000};
      play_requests(0, 0);

      // zero window length, shift written with its top bit set so it gets masked
      program_registers(CSR_DATA_W'(0), CSR_DATA_W'(31));
      position_queue = '{32'h1234_5678, 32'h8000_0000, 32'h0000_0005};
      play_requests(0, 0);

      // longest window, reaching back over slots written earlier
      program_registers(CSR_DATA_W'(31), CSR_DATA_W'(0));
      position_queue = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0100, 32'h0000_0200,
                         32'hffff_ff00, 32'h0000_0000};
      play_requests(0, 0);

      // random phases: register extremes and small lengths first, then random settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         length_value = CSR_DATA_W'($urandom_range(31));
         shift_value  = CSR_DATA_W'($urandom_range(31));
         case (phase)
            0: begin
               length_value = CSR_DATA_W'(1);
               shift_value  = CSR_DATA_W'(0);
            end
            1: begin
               length_value = CSR_DATA_W'(31);
               shift_value  = CSR_DATA_W'(15);
            end
            2: length_value = CSR_DATA_W'(0);
            3: length_value = CSR_DATA_W'(2);
            default: ;
         endcase
         program_registers(length_value, shift_value);
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            last_position = next_position(last_position);
            position_queue.push_back(last_position);
         end
         // idle pattern: none, sender, receiver, both
         case (phase % 4)
            0:       play_requests(0, 0);
            1:       play_requests(BUSY_PCT, 0);
            2:       play_requests(0, BUSY_PCT);
            default: play_requests(SHARED_PCT, SHARED_PCT);
         endcase
      end

      // let the datapath settle past its latency before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predictor.pending() != 0)
         $error("velocity responses still outstanding: %0d", predictor.pending());
      if (predictor.failures == 0 && predictor.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/wve_pkg.sv
rtl/core/wve_ram.sv
rtl/core/wve_ctrl.sv
rtl/core/wve_dpath.sv
rtl/core/windowed_velocity_estimator_top.sv
tb/windowed_velocity_estimator_top_tb.sv
